// ----- design/text_console_cell_buffer_macros.svh -----
`ifndef TEXT_CONSOLE_CELL_BUFFER_MACROS_SVH
`define TEXT_CONSOLE_CELL_BUFFER_MACROS_SVH

// clocked check that is switched off while reset is held
`define TCCB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define TCCB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tccb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tccb_pkg;

    // console action codes
    typedef enum logic [2:0] {
        ACT_CLEAR_ALL = 3'd0,
        ACT_PUT_CHAR  = 3'd1,
        ACT_NEW_LINE  = 3'd2,
        ACT_BACKSPACE = 3'd3,
        ACT_CLEAR_ROW = 3'd4,
        ACT_READ_CELL = 3'd5
    } t_action;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_WIPE,
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_SCROLL,
        S_SCR_END,
        S_FILL,
        S_DONE
    } t_state;

    // address unit operations
    typedef enum logic [1:0] {
        AGU_HOLD,
        AGU_LOAD,
        AGU_STEP
    } t_agu_op;

    // offset applied on load
    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_INC,
        ADJ_DEC
    } t_adj;

    typedef struct packed {
        t_agu_op op;
        t_adj    adj;
    } t_agu_ctl;

    localparam logic [7:0] BLANK   = 8'h20;
    localparam logic [7:0] NL_MARK = 8'h0A;

    localparam int ACTION_W = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

endpackage

`default_nettype wire

// ----- design/text_console_cell_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Text console cell buffer: a ROWS x COLUMNS grid of character bytes and a cursor.
// Input channel (s side): one word is one console action; tuser carries the action
// code, tdata the character, line count and the cell to read. Output channel (m side):
// one word per action with the read cell value (zero unless a read) and the cursor.
// Only one action is in flight: tready is high only while the sequencer is idle.
// Simple actions (put char, new line without scroll, backspace, read, unknown codes)
// pass through S_ADDR, S_EXEC and S_DONE back to idle; the word is loaded into the
// output register on leaving S_DONE. Clear row and clear all add a fill walk over
// the row or the whole grid, and a new line on the bottom row adds a scroll walk,
// then a fill of the bottom row. The walks are bound by the single write port of
// the cell memory, which they visit one cell per cycle, and by the shared address
// unit that forms every row*COLUMNS+col address as a registered value.
// After reset a clearing pass writes spaces to every cell with tready low; the cursor
// resets to (0,0).
// A stalled receiver holds the result in the output register; the block still
// finishes the next action and then waits until that register is free.

module text_console_cell_buffer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] char_code, [15:8] line_len, [20:16] read_row, [27:21] read_col
    input  wire  [tccb_pkg::S_DATA_W-1:0]    i_s_tdata,
    // [2:0] action
    input  wire  [tccb_pkg::ACTION_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // [7:0] cell_value, [14:8] cursor_col, [19:15] cursor_row
    output logic [tccb_pkg::M_DATA_W-1:0]    o_m_tdata
);

`include "text_console_cell_buffer_macros.svh"

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int AW     = $clog2(NCELLS + 1);
    localparam int MW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);

    tccb_pkg::t_state  r_state, n_state;
    tccb_pkg::t_action r_action;

    logic [CW-1:0] r_cur_col;
    logic [RW-1:0] r_cur_row;
    logic [7:0]    r_char;
    logic [7:0]    r_count;
    logic [RW-1:0] r_rrow;
    logic [CW-1:0] r_rcol;
    logic          r_rd_ok;
    logic [MW-1:0] r_cnt;
    logic          r_scr_v;
    logic [MW-1:0] r_scr_addr;
    logic          r_out_valid;
    logic [7:0]    r_out_value;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;

    tccb_pkg::t_agu_ctl agu_ctl;
    logic [RW-1:0]      agu_row;
    logic [CW-1:0]      agu_col;
    logic [AW-1:0]      agu_addr;
    logic               agu_in_grid;

    logic          ram_we;
    logic [MW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    logic accept;
    logic out_free;
    logic last_row;
    logic last_col;
    logic bs_ok;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign last_row = (r_cur_row == RW'(ROWS - 1));
    assign last_col = (r_cur_col == CW'(COLUMNS - 1));
    assign bs_ok    = (r_count != 8'd0) && !((r_cur_row == '0) && (r_cur_col == '0));

    // shared address unit
    tccb_agu #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_agu (
        .i_clk     (i_clk),
        .i_ctl     (agu_ctl),
        .i_row     (agu_row),
        .i_col     (agu_col),
        .o_addr    (agu_addr),
        .o_in_grid (agu_in_grid)
    );

    // cell memory
    tccb_ram #(
        .WIDTH (8),
        .DEPTH (NCELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (agu_addr[MW-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tccb_pkg::S_INIT: n_state = tccb_pkg::S_WIPE;
            tccb_pkg::S_WIPE: begin
                if (r_cnt == '0) n_state = tccb_pkg::S_IDLE;
            end
            tccb_pkg::S_IDLE: begin
                if (accept) n_state = tccb_pkg::S_ADDR;
            end
            tccb_pkg::S_ADDR: n_state = tccb_pkg::S_EXEC;
            tccb_pkg::S_EXEC: begin
                unique case (r_action) inside
                    tccb_pkg::ACT_CLEAR_ALL,
                    tccb_pkg::ACT_CLEAR_ROW: n_state = tccb_pkg::S_FILL;
                    tccb_pkg::ACT_NEW_LINE:
                        n_state = last_row ? tccb_pkg::S_SCROLL : tccb_pkg::S_DONE;
                    default: n_state = tccb_pkg::S_DONE;
                endcase
            end
            tccb_pkg::S_SCROLL: begin
                if (r_cnt == '0) n_state = tccb_pkg::S_SCR_END;
            end
            tccb_pkg::S_SCR_END: n_state = tccb_pkg::S_FILL;
            tccb_pkg::S_FILL: begin
                if (r_cnt == '0) n_state = tccb_pkg::S_DONE;
            end
            tccb_pkg::S_DONE: begin
                if (out_free) n_state = tccb_pkg::S_IDLE;
            end
            default: n_state = tccb_pkg::S_INIT;
        endcase
    end

    // address unit and memory control
    always_comb begin
        agu_ctl.op  = tccb_pkg::AGU_HOLD;
        agu_ctl.adj = tccb_pkg::ADJ_NONE;
        agu_row     = '0;
        agu_col     = '0;
        ram_we      = 1'b0;
        ram_waddr   = agu_addr[MW-1:0];
        ram_wdata   = tccb_pkg::BLANK;
        ram_re      = 1'b0;
        o_s_tready  = 1'b0;
        unique case (r_state) inside
            tccb_pkg::S_INIT: agu_ctl.op = tccb_pkg::AGU_LOAD;
            tccb_pkg::S_WIPE, tccb_pkg::S_FILL: begin
                ram_we     = 1'b1;
                agu_ctl.op = tccb_pkg::AGU_STEP;
            end
            tccb_pkg::S_IDLE: o_s_tready = 1'b1;
            tccb_pkg::S_ADDR: begin
                agu_ctl.op = tccb_pkg::AGU_LOAD;
                agu_row    = r_cur_row;
                agu_col    = r_cur_col;
                unique case (r_action)
                    tccb_pkg::ACT_CLEAR_ALL: begin
                        agu_row = '0;
                        agu_col = '0;
                    end
                    tccb_pkg::ACT_NEW_LINE:  agu_ctl.adj = tccb_pkg::ADJ_INC;
                    tccb_pkg::ACT_BACKSPACE: agu_ctl.adj = tccb_pkg::ADJ_DEC;
                    tccb_pkg::ACT_CLEAR_ROW: agu_col = '0;
                    tccb_pkg::ACT_READ_CELL: begin
                        agu_row = r_rrow;
                        agu_col = r_rcol;
                    end
                    default: ;
                endcase
            end
            tccb_pkg::S_EXEC: begin
                unique case (r_action)
                    tccb_pkg::ACT_PUT_CHAR: begin
                        ram_we    = 1'b1;
                        ram_wdata = r_char;
                    end
                    tccb_pkg::ACT_NEW_LINE: begin
                        // mark past the last cell is dropped
                        ram_we    = agu_in_grid;
                        ram_wdata = tccb_pkg::NL_MARK;
                        if (last_row) begin
                            agu_ctl.op = tccb_pkg::AGU_LOAD;
                            agu_row    = RW'(1);
                        end
                    end
                    tccb_pkg::ACT_BACKSPACE: ram_we = bs_ok;
                    tccb_pkg::ACT_READ_CELL: ram_re = r_rd_ok;
                    default: ;
                endcase
            end
            tccb_pkg::S_SCROLL: begin
                ram_re     = 1'b1;
                agu_ctl.op = tccb_pkg::AGU_STEP;
            end
            tccb_pkg::S_SCR_END: begin
                agu_ctl.op = tccb_pkg::AGU_LOAD;
                agu_row    = RW'(ROWS - 1);
            end
            default: ;
        endcase
        // scroll write-back, one row up, newline marks become spaces
        if (r_scr_v) begin
            ram_we    = 1'b1;
            ram_waddr = r_scr_addr - MW'(COLUMNS);
            ram_wdata = (ram_rdata == tccb_pkg::NL_MARK) ? tccb_pkg::BLANK : ram_rdata;
        end
    end

    // sequencer and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tccb_pkg::S_INIT;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_cnt     <= '0;
            r_scr_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scr_v <= (r_state == tccb_pkg::S_SCROLL);
            unique case (r_state) inside
                tccb_pkg::S_INIT: r_cnt <= MW'(NCELLS - 1);
                tccb_pkg::S_WIPE, tccb_pkg::S_FILL, tccb_pkg::S_SCROLL:
                    r_cnt <= r_cnt - MW'(1);
                tccb_pkg::S_SCR_END: r_cnt <= MW'(COLUMNS - 1);
                tccb_pkg::S_EXEC: begin
                    unique case (r_action)
                        tccb_pkg::ACT_CLEAR_ALL: begin
                            r_cnt     <= MW'(NCELLS - 1);
                            r_cur_col <= '0;
                            r_cur_row <= '0;
                        end
                        tccb_pkg::ACT_PUT_CHAR: begin
                            r_cur_col <= last_col ? '0 : r_cur_col + CW'(1);
                        end
                        tccb_pkg::ACT_NEW_LINE: begin
                            r_cur_col <= '0;
                            r_cnt     <= MW'(NCELLS - COLUMNS - 1);
                            if (!last_row) r_cur_row <= r_cur_row + RW'(1);
                        end
                        tccb_pkg::ACT_BACKSPACE: begin
                            if (bs_ok) begin
                                if (r_cur_col == '0) begin
                                    r_cur_col <= CW'(COLUMNS - 1);
                                    r_cur_row <= r_cur_row - RW'(1);
                                end else begin
                                    r_cur_col <= r_cur_col - CW'(1);
                                end
                            end
                        end
                        tccb_pkg::ACT_CLEAR_ROW: r_cnt <= MW'(COLUMNS - 1);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // capture the accepted word and the scroll read address
    always_ff @(posedge i_clk) begin
        r_scr_addr <= agu_addr[MW-1:0];
        if (accept) begin
            r_action <= tccb_pkg::t_action'(i_s_tuser);
            r_char   <= i_s_tdata[7:0];
            r_count  <= i_s_tdata[15:8];
            r_rrow   <= RW'(i_s_tdata[20:16]);
            r_rcol   <= CW'(i_s_tdata[27:21]);
            r_rd_ok  <= (32'(i_s_tdata[20:16]) < ROWS) && (32'(i_s_tdata[27:21]) < COLUMNS);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tccb_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tccb_pkg::S_DONE && out_free) begin
            r_out_value <= (r_action == tccb_pkg::ACT_READ_CELL && r_rd_ok) ? ram_rdata : 8'd0;
            r_out_col   <= 7'(r_cur_col);
            r_out_row   <= 5'(r_cur_row);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_row, r_out_col, r_out_value};

    // checks
    `TCCB_ASSERT(a_one_in_flight, i_clk, i_rst_n, accept |=> !o_s_tready, "second word taken while busy")
    `TCCB_ASSERT(a_cursor_in_grid, i_clk, i_rst_n, (r_cur_row < RW'(ROWS - 1)) || (r_cur_row == RW'(ROWS - 1)) |-> (r_cur_col < CW'(COLUMNS - 1)) || last_col, "cursor left the grid")
    `TCCB_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(r_state) == tccb_pkg::S_DONE, "result without finished action")
    `TCCB_ASSERT_ALWAYS(a_reset_blocks_input, i_clk, !i_rst_n |=> !o_s_tready, "input open during clearing pass")

endmodule

`default_nettype wire

// ----- design/tccb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tccb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tccb_agu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tccb_agu #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                                 i_clk,
    input  tccb_pkg::t_agu_ctl                  i_ctl,
    input  wire  [$clog2(ROWS)-1:0]             i_row,
    input  wire  [$clog2(COLUMNS)-1:0]          i_col,
    output logic [$clog2(COLUMNS*ROWS+1)-1:0]   o_addr,
    output logic                                o_in_grid
);

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int AW     = $clog2(NCELLS + 1);

    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] w_base;

    // row base from a constant multiply, then column and offset
    always_comb begin
        w_base = AW'(i_row) * AW'(COLUMNS) + AW'(i_col);
        n_addr = r_addr;
        unique case (i_ctl.op)
            tccb_pkg::AGU_LOAD: begin
                unique case (i_ctl.adj)
                    tccb_pkg::ADJ_INC: n_addr = w_base + AW'(1);
                    tccb_pkg::ADJ_DEC: n_addr = w_base - AW'(1);
                    default:           n_addr = w_base;
                endcase
            end
            tccb_pkg::AGU_STEP: n_addr = r_addr + AW'(1);
            default:            n_addr = r_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    assign o_addr    = r_addr;
    assign o_in_grid = (r_addr < AW'(NCELLS));

endmodule

`default_nettype wire

// ----- bench/text_console_cell_buffer_checker.sv -----
`timescale 1ns / 1ps

// watches both channels of the console buffer, keeps its own copy of the grid
// and the cursor, and compares every result word with the predicted one
module text_console_cell_buffer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    // [7:0] char_code, [15:8] line_len, [20:16] read_row, [27:21] read_col
    input  wire  [tccb_pkg::S_DATA_W-1:0]    i_s_tdata,
    // [2:0] action
    input  wire  [tccb_pkg::ACTION_W-1:0]    i_s_tuser,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    // [7:0] cell_value, [14:8] cursor_col, [19:15] cursor_row
    input  wire  [tccb_pkg::M_DATA_W-1:0]    i_m_tdata,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int NCELLS = COLUMNS * ROWS;

    // one result word, same layout as the low bits of the m side tdata
    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_value;
    } t_console_report;

    logic [7:0]      screen [NCELLS];
    logic [6:0]      cur_col;
    logic [4:0]      cur_row;
    t_console_report awaited_reports [$];
    int              mismatches = 0;

    // every cell back to a space
    function automatic void blank_screen();
        for (int i = 0; i < NCELLS; i++) screen[i] = tccb_pkg::BLANK;
    endfunction

    // carry out one console action on the shadow grid, return the word it gives
    function automatic t_console_report apply_console_action(
        logic [2:0] act,
        logic [7:0] ch,
        logic [7:0] cnt,
        logic [4:0] rr,
        logic [6:0] rc
    );
        t_console_report rep;
        int              pos;
        rep = '0;
        pos = cur_row * COLUMNS + cur_col;
        case (act)
            tccb_pkg::ACT_CLEAR_ALL: begin
                blank_screen();
                cur_col = '0;
                cur_row = '0;
            end
            tccb_pkg::ACT_PUT_CHAR: begin
                screen[pos] = ch;
                cur_col = (cur_col == COLUMNS - 1) ? '0 : cur_col + 7'd1;
            end
            tccb_pkg::ACT_NEW_LINE: begin
                // the mark falls off the grid when the cursor is on the last cell
                if (pos + 1 < NCELLS) screen[pos + 1] = tccb_pkg::NL_MARK;
                cur_col = '0;
                if (cur_row != ROWS - 1) begin
                    cur_row = cur_row + 5'd1;
                end else begin
                    // scroll: rows move up, newline marks turn into spaces
                    for (int i = COLUMNS; i < NCELLS; i++)
                        screen[i - COLUMNS] = (screen[i] == tccb_pkg::NL_MARK) ?
                                              tccb_pkg::BLANK : screen[i];
                    for (int i = NCELLS - COLUMNS; i < NCELLS; i++)
                        screen[i] = tccb_pkg::BLANK;
                    cur_row = 5'(ROWS - 1);
                end
            end
            tccb_pkg::ACT_BACKSPACE: begin
                if (cnt != 0 && pos != 0) begin
                    screen[pos - 1] = tccb_pkg::BLANK;
                    if (cur_col == 0) begin
                        cur_row = cur_row - 5'd1;
                        cur_col = 7'(COLUMNS - 1);
                    end else begin
                        cur_col = cur_col - 7'd1;
                    end
                end
            end
            tccb_pkg::ACT_CLEAR_ROW: begin
                for (int i = 0; i < COLUMNS; i++)
                    screen[cur_row * COLUMNS + i] = tccb_pkg::BLANK;
            end
            tccb_pkg::ACT_READ_CELL: begin
                if (rr < ROWS && rc < COLUMNS) rep.cell_value = screen[rr * COLUMNS + rc];
            end
            default: begin
            end
        endcase
        rep.cursor_col = cur_col;
        rep.cursor_row = cur_row;
        return rep;
    endfunction

    // predict on accepted actions, compare on accepted result words
    always @(posedge i_clk) begin
        t_console_report got;
        t_console_report want;
        if (!i_rst_n) begin
            blank_screen();
            cur_col = '0;
            cur_row = '0;
            awaited_reports.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                awaited_reports.push_back(apply_console_action(i_s_tuser, i_s_tdata[7:0],
                    i_s_tdata[15:8], i_s_tdata[20:16], i_s_tdata[27:21]));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[19:0];
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: word with none expected, actual %h", $time, got);
                end else begin
                    want = awaited_reports.pop_front();
                    if (got.cell_value !== want.cell_value) begin
                        mismatches++;
                        $display("%0t: cell_value expected %h actual %h",
                                 $time, want.cell_value, got.cell_value);
                    end
                    if (got.cursor_col !== want.cursor_col) begin
                        mismatches++;
                        $display("%0t: cursor_col expected %0d actual %0d",
                                 $time, want.cursor_col, got.cursor_col);
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        mismatches++;
                        $display("%0t: cursor_row expected %0d actual %0d",
                                 $time, want.cursor_row, got.cursor_row);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_reports.size();
    end

endmodule

// ----- bench/text_console_cell_buffer_test.sv -----
`timescale 1ns / 1ps

module text_console_cell_buffer_test;

    // codes the block does not define, sent to check that they change nothing
    localparam logic [2:0] ACT_RESERVED_6 = 3'd6;
    localparam logic [2:0] ACT_RESERVED_7 = 3'd7;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 460;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    wire                              o_s_tready;
    // [7:0] char_code, [15:8] line_len, [20:16] read_row, [27:21] read_col
    logic [tccb_pkg::S_DATA_W-1:0]    i_s_tdata;
    // [2:0] action
    logic [tccb_pkg::ACTION_W-1:0]    i_s_tuser;
    wire                              o_m_tvalid;
    logic                             i_m_tready;
    // [7:0] cell_value, [14:8] cursor_col, [19:15] cursor_row
    wire  [tccb_pkg::M_DATA_W-1:0]    o_m_tdata;

    int fail_count;
    int pending;
    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_request;
    int action_tally [8];

    text_console_cell_buffer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    text_console_cell_buffer_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // offer one action and wait until it is accepted, then idle at random
    task automatic send_action(
        logic [2:0] act,
        logic [7:0] ch,
        logic [7:0] cnt,
        logic [4:0] rr,
        logic [6:0] rc
    );
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {4'b0, rc, rr, cnt, ch};
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        action_tally[act]++;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop offering until every word in flight has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // unconstrained values for fields an action ignores
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [4:0] any_row();
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [6:0] any_col();
        return 7'($urandom_range(127));
    endfunction

    function automatic logic [7:0] pick_char();
        return ($urandom_range(99) < 70) ? 8'($urandom_range(8'h7E, 8'h20)) :
                                           8'($urandom_range(255));
    endfunction

    // random editing sessions: typed runs, erasing, reads and some noise
    task automatic run_random_phase(int quota);
        int sent;
        int kind;
        int n;
        logic [4:0] rr;
        logic [6:0] rc;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(99);
            if (kind < 42) begin
                // typed run, often closed by a new line
                n = $urandom_range(12, 1);
                repeat (n) send_action(tccb_pkg::ACT_PUT_CHAR, pick_char(), any_byte(),
                                       any_row(), any_col());
                sent += n;
                if ($urandom_range(99) < 40) begin
                    send_action(tccb_pkg::ACT_NEW_LINE, any_byte(), any_byte(),
                                any_row(), any_col());
                    sent++;
                end
            end else if (kind < 56) begin
                // erasing, mostly with a nonzero line count
                n = $urandom_range(6, 1);
                repeat (n)
                    send_action(tccb_pkg::ACT_BACKSPACE, any_byte(),
                        ($urandom_range(99) < 85) ? 8'($urandom_range(255, 1)) : 8'd0,
                        any_row(), any_col());
                sent += n;
            end else if (kind < 76) begin
                // reads, biased toward the typing area at the bottom left
                n = $urandom_range(4, 1);
                repeat (n) begin
                    case ($urandom_range(2))
                        0: begin
                            rr = 5'($urandom_range(24, 22));
                            rc = 7'($urandom_range(15));
                        end
                        1: begin
                            rr = 5'($urandom_range(24));
                            rc = 7'($urandom_range(79));
                        end
                        default: begin
                            rr = any_row();
                            rc = any_col();
                        end
                    endcase
                    send_action(tccb_pkg::ACT_READ_CELL, any_byte(), any_byte(), rr, rc);
                end
                sent += n;
            end else if (kind < 84) begin
                send_action(tccb_pkg::ACT_CLEAR_ROW, any_byte(), any_byte(),
                            any_row(), any_col());
                sent++;
            end else if (kind < 86) begin
                // full-width line: ends on the last column, then new line
                send_action(tccb_pkg::ACT_NEW_LINE, 8'd0, 8'd0, 5'd0, 7'd0);
                repeat (79) send_action(tccb_pkg::ACT_PUT_CHAR, pick_char(), 8'd1,
                                        5'd0, 7'd0);
                send_action(tccb_pkg::ACT_NEW_LINE, 8'd0, 8'd0, 5'd0, 7'd0);
                sent += 81;
            end else if (kind < 88) begin
                send_action($urandom_range(1) ? ACT_RESERVED_7 : ACT_RESERVED_6,
                            any_byte(), any_byte(), any_row(), any_col());
                sent++;
            end else if (kind < 89) begin
                send_action(tccb_pkg::ACT_CLEAR_ALL, any_byte(), any_byte(),
                            any_row(), any_col());
                sent++;
            end else begin
                send_action(tccb_pkg::ACT_NEW_LINE, any_byte(), any_byte(),
                            any_row(), any_col());
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n           <= 1'b0;
        i_s_tvalid        <= 1'b0;
        i_s_tuser         <= '0;
        i_s_tdata         <= '0;
        hold_request      = 1'b0;
        sender_idle_pct   = 25;
        receiver_idle_pct = 50;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners of the fields and the special cases
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_PUT_CHAR, 8'h00, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_PUT_CHAR, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd1);
        send_action(tccb_pkg::ACT_READ_CELL, 8'hFF, 8'hFF, 5'd24, 7'd79);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'h1F, 7'h7F);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd80);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd25, 7'd0);
        send_action(tccb_pkg::ACT_BACKSPACE, 8'd0, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_BACKSPACE, 8'd0, 8'hFF, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_NEW_LINE, 8'd0, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd2);
        // backspace from column 0 lands on the last column of the row above
        send_action(tccb_pkg::ACT_BACKSPACE, 8'd0, 8'd1, 5'd0, 7'd0);
        // put char on the last column wraps to column 0 of the same row
        send_action(tccb_pkg::ACT_PUT_CHAR, 8'h41, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd79);
        send_action(tccb_pkg::ACT_CLEAR_ROW, 8'd0, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd79);
        send_action(ACT_RESERVED_6, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        send_action(ACT_RESERVED_7, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        send_action(tccb_pkg::ACT_CLEAR_ALL, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
        // backspace on the first cell changes nothing
        send_action(tccb_pkg::ACT_BACKSPACE, 8'd0, 8'd1, 5'd0, 7'd0);
        // walk to the bottom row, fill it, new line on the last cell
        repeat (24) send_action(tccb_pkg::ACT_NEW_LINE, 8'd0, 8'd0, 5'd0, 7'd0);
        repeat (79) send_action(tccb_pkg::ACT_PUT_CHAR, 8'h0A, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_NEW_LINE, 8'd0, 8'd0, 5'd0, 7'd0);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd23, 7'd5);
        send_action(tccb_pkg::ACT_READ_CELL, 8'd0, 8'd0, 5'd24, 7'd0);

        run_random_phase(PHASE_ITEMS);
        drain_results();

        sender_idle_pct   = 50;
        receiver_idle_pct = 25;
        run_random_phase(PHASE_ITEMS);
        drain_results();

        // no idling, but one long hold-off on the result side
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 1'b1;
        run_random_phase(PHASE_ITEMS);
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("actions run: %0d clear all, %0d put char, %0d new line, %0d backspace",
                 action_tally[tccb_pkg::ACT_CLEAR_ALL], action_tally[tccb_pkg::ACT_PUT_CHAR],
                 action_tally[tccb_pkg::ACT_NEW_LINE], action_tally[tccb_pkg::ACT_BACKSPACE]);
        $display("%0d clear row, %0d read, %0d undefined codes; three stall mixes, long hold",
                 action_tally[tccb_pkg::ACT_CLEAR_ROW], action_tally[tccb_pkg::ACT_READ_CELL],
                 action_tally[ACT_RESERVED_6] + action_tally[ACT_RESERVED_7]);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
